### src/bsf_pkg.sv
// package: payload types, configuration codes and sequencer phases of the framer
package bsf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FLAG   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE = CfgIdxW'(1);

  // reset values of the configuration registers
  localparam logic [ByteW-1:0] FLAG_RESET   = 8'h24;
  localparam logic [ByteW-1:0] ESCAPE_RESET = 8'h2f;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_last;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_trailer;
    logic             run_last;
  } out_t;

  typedef struct packed {
    logic [ByteW-1:0] flag_value;
    logic [ByteW-1:0] escape_value;
  } cfg_t;

  // which result of the held request goes out next
  typedef enum logic [2:0] {
    PH_OPEN,
    PH_ESC,
    PH_DATA,
    PH_CLOSE,
    PH_TRAIL
  } phase_e;

  // 8-bit one's complement add with end-around carry
  function automatic logic [ByteW-1:0] oc_add(logic [ByteW-1:0] a, logic [ByteW-1:0] b);
    logic [ByteW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ByteW-1:0] + {{(ByteW-1){1'b0}}, s[ByteW]};
  endfunction

endpackage

### src/bsf_cfg.sv
// configuration registers: flag and escape byte values
module bsf_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bsf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bsf_pkg::ByteW-1:0]   cfg_data_i,
  output bsf_pkg::cfg_t               cfg_o
);
  import bsf_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // decode the register index, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FLAG:   cfg_d.flag_value   = cfg_data_i;
        CFG_ESCAPE: cfg_d.escape_value = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_value   <= FLAG_RESET;
      cfg_q.escape_value <= ESCAPE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### src/bsf_seq.sv
// input register and result sequencer: one framed byte per cycle from the held request while res_free_i is high
module bsf_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bsf_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bsf_pkg::in_t  in_data_i,
  input  logic          res_free_i,
  output logic          res_load_o,
  output bsf_pkg::out_t res_data_o
);
  import bsf_pkg::*;

  in_t              item_q;
  logic             item_vld_q, item_vld_d;
  phase_e           phase_q, phase_d;
  logic             inside_q, inside_d;
  logic [ByteW-1:0] sum_q, sum_d;

  logic             match_held, match_new;
  logic             final_res;
  logic             take;
  phase_e           phase_next;
  logic [ByteW-1:0] res_byte;

  assign match_held = (item_q.data_byte == cfg_i.flag_value) ||
                      (item_q.data_byte == cfg_i.escape_value);
  assign match_new  = (in_data_i.data_byte == cfg_i.flag_value) ||
                      (in_data_i.data_byte == cfg_i.escape_value);

  assign res_load_o = item_vld_q && res_free_i;

  // byte, sum and next phase for the current phase
  always_comb begin
    res_byte   = item_q.data_byte;
    phase_next = PH_DATA;
    final_res  = 1'b0;
    sum_d      = sum_q;
    inside_d   = inside_q;
    unique case (phase_q)
      PH_OPEN: begin
        res_byte   = cfg_i.flag_value;
        phase_next = match_held ? PH_ESC : PH_DATA;
        sum_d      = cfg_i.flag_value;
        inside_d   = 1'b1;
      end
      PH_ESC: begin
        res_byte   = cfg_i.escape_value;
        phase_next = PH_DATA;
        sum_d      = oc_add(sum_q, cfg_i.escape_value);
      end
      PH_DATA: begin
        res_byte   = item_q.data_byte;
        phase_next = PH_CLOSE;
        final_res  = !item_q.frame_last;
        sum_d      = oc_add(sum_q, item_q.data_byte);
      end
      PH_CLOSE: begin
        res_byte   = cfg_i.flag_value;
        phase_next = PH_TRAIL;
        sum_d      = oc_add(sum_q, cfg_i.flag_value);
      end
      PH_TRAIL: begin
        res_byte   = ~sum_q;
        phase_next = PH_TRAIL;
        final_res  = 1'b1;
        sum_d      = '0;
        inside_d   = 1'b0;
      end
      default: begin
        res_byte   = item_q.data_byte;
        phase_next = PH_DATA;
      end
    endcase
    if (!res_load_o) begin
      sum_d    = sum_q;
      inside_d = inside_q;
    end
  end

  assign res_data_o.out_byte   = res_byte;
  assign res_data_o.is_trailer = (phase_q == PH_TRAIL);
  assign res_data_o.run_last   = final_res;

  // a new request enters when the register is empty or its last result leaves now
  assign in_stall_o = item_vld_q && !(res_load_o && final_res);
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    item_vld_d = item_vld_q;
    phase_d    = phase_q;
    if (res_load_o) begin
      phase_d = phase_next;
      if (final_res) begin
        item_vld_d = 1'b0;
      end
    end
    if (take) begin
      item_vld_d = 1'b1;
      if (!inside_d) begin
        phase_d = PH_OPEN;
      end else if (match_new) begin
        phase_d = PH_ESC;
      end else begin
        phase_d = PH_DATA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      phase_q    <= PH_OPEN;
      inside_q   <= 1'b0;
      sum_q      <= '0;
    end else begin
      item_vld_q <= item_vld_d;
      phase_q    <= phase_d;
      inside_q   <= inside_d;
      sum_q      <= sum_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_data_i;
    end
  end

endmodule

### src/bsf_out.sv
// result register between the sequencer and the output channel
module bsf_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_load_i,
  input  bsf_pkg::out_t res_data_i,
  output logic          res_free_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bsf_pkg::out_t out_data_o
);
  import bsf_pkg::*;

  logic out_vld_q, out_vld_d;
  out_t out_q;

  assign res_free_o  = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // valid is set by loads and cleared when the output is not stalled
  always_comb begin
    out_vld_d = out_vld_q;
    if (res_load_i) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      out_q <= res_data_i;
    end
  end

endmodule

### src/byte_stuff_framer_checksum.sv
// top level: byte-stuffing framer with one's complement checksum trailer
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   in      | input     | in_valid_i/in_stall_o | data_byte, frame_last
//   out     | output    | out_valid_o/out_stall_i | out_byte, is_trailer, run_last
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// each request has one to five results: the sequencer puts one framed byte per cycle
// into the result register while that register is free.
// a new request is taken in the cycle its predecessor's last result is loaded.
// reset clears the frame state, the checksum and both valid flags.
// a stalled output holds the result register and, through it, the input.
module byte_stuff_framer_checksum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bsf_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bsf_pkg::out_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bsf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bsf_pkg::ByteW-1:0]   cfg_data_i
);
  import bsf_pkg::*;

  cfg_t cfg;
  logic res_load;
  logic res_free;
  out_t res_data;

  // configuration registers
  bsf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register and sequencer
  bsf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_free_i (res_free),
    .res_load_o (res_load),
    .res_data_o (res_data)
  );

  // result register
  bsf_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_load_i  (res_load),
    .res_data_i  (res_data),
    .res_free_o  (res_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
